FILE: rtl/awm_pkg.sv
// Package for the sliding-window anagram matcher.
// Holds the request codes, byte constants and the count-table port struct.
// No dependencies.
package awm_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned NumBytes = 256;
  localparam int unsigned PosW     = 32;

  typedef enum logic [1:0] {
    REQ_CLEAR   = 2'd0,
    REQ_PATTERN = 2'd1,
    REQ_TEXT    = 2'd2,
    REQ_RESTART = 2'd3
  } req_e;

  typedef struct packed {
    logic             en;
    logic [ByteW-1:0] addr;
  } tbl_port_t;

endpackage

FILE: rtl/awm_cnt_tbl.sv
// Per-byte count table: 256 entries, one read and one write port, read data registered.
// Valid bits give zero for entries not written since the last clear.
// Depends on awm_pkg.
module awm_cnt_tbl #(
  parameter int unsigned CntW = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  clear_i,
  input  awm_pkg::tbl_port_t    rd_i,
  input  awm_pkg::tbl_port_t    wr_i,
  input  logic [CntW-1:0]       wdata_i,
  output logic [CntW-1:0]       rdata_o
);
  import awm_pkg::*;

  logic [CntW-1:0] mem [NumBytes];
  logic [NumBytes-1:0] valid_q;
  logic [CntW-1:0] rdata_q;
  logic            rvalid_q;
  logic            fwd_q;
  logic [CntW-1:0] fwd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      fwd_q    <= 1'b0;
    end else begin
      if (clear_i) begin
        valid_q <= '0;
      end else if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvalid_q <= valid_q[rd_i.addr];
        fwd_q    <= wr_i.en && !clear_i && (wr_i.addr == rd_i.addr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q    <= mem[rd_i.addr];
      fwd_data_q <= wdata_i;
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : (rvalid_q ? rdata_q : '0);

endmodule

FILE: rtl/awm_ring_buf.sv
// Ring buffer of the text bytes in the current window.
// One write and one read port, read data registered; no dependencies beyond awm_pkg.
module awm_ring_buf #(
  parameter int unsigned Depth = 256,
  parameter int unsigned AddrW = 8
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [awm_pkg::ByteW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [awm_pkg::ByteW-1:0] rd_data_o
);
  import awm_pkg::*;

  logic [ByteW-1:0] mem [Depth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/anagram_window_matcher_unit.sv
// Top level of the sliding-window anagram matcher: control, stages and output queue.
// Depends on awm_pkg, awm_cnt_tbl and awm_ring_buf.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | req_type_i, data_byte_i
//   out     | output    | out_valid_o/out_stall_i| start_index_o
//
// With a pattern loaded, a text beat stalls the input in its b stage: the count tables
// have one read port, used first for the incoming byte and then, if the window is full,
// for the byte that leaves it. A pattern beat with room stalls the input in its p stage;
// clear, restart, text with no pattern and a pattern beat with no room do not. The input
// also stalls while the two-entry result queue is full. Results, pushed in the b stage,
// are offered from the registered queue. Reset clears control state and table valid bits.
module anagram_window_matcher_unit #(
  parameter int unsigned MAX_PATTERN = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                req_type_i,
  input  logic [awm_pkg::ByteW-1:0] data_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [awm_pkg::PosW-1:0]  start_index_o
);
  import awm_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_PATTERN + 1);
  localparam int unsigned RingAw = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned QDepth = 2;

  logic [CntW-1:0]   pat_len_q, pat_len_d;
  logic [CntW-1:0]   distinct_q, distinct_d;
  logic [CntW-1:0]   matched_q, matched_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [RingAw-1:0] ring_ptr_q, ring_ptr_d;
  logic [PosW-1:0]   text_pos_q, text_pos_d;

  logic              b_vld_q, b_vld_d;
  logic              p_vld_q, p_vld_d;
  logic [ByteW-1:0]  b_byte_q, b_byte_d;
  logic [PosW-1:0]   b_start_q, b_start_d;
  logic              b_retire_q, b_retire_d;
  logic              b_ring_fwd_q, b_ring_fwd_d;
  logic              d_vld_q, d_vld_d;
  logic [ByteW-1:0]  d_byte_q, d_byte_d;

  logic [PosW-1:0]   q_data_q [QDepth];
  logic [PosW-1:0]   q_data_d [QDepth];
  logic [1:0]        q_cnt_q, q_cnt_d;

  logic              accept;
  logic              acc_clear, acc_pat, acc_txt, acc_restart;
  logic              txt_active, pat_room, win_clear;
  logic [RingAw-1:0] oldest;
  logic [CntW-1:0]   fill_inc;
  logic              ptr_last;
  logic [ByteW-1:0]  ring_rd, ring_byte;
  logic              q_push, q_pop;
  logic [1:0]        q_wr_idx;

  tbl_port_t         need_rd, need_wr, win_rd, win_wr;
  logic [CntW-1:0]   need_rdata, need_wdata, win_rdata, win_wdata;
  logic [CntW-1:0]   win_b_new, win_d_new, matched_b;
  logic              inc_b, dec_d, match_hit;

  assign in_stall_o  = b_vld_q | p_vld_q | (q_cnt_q == 2'(QDepth));
  assign accept      = in_valid_i & !in_stall_o;
  assign acc_clear   = accept && (req_type_i == REQ_CLEAR);
  assign acc_pat     = accept && (req_type_i == REQ_PATTERN);
  assign acc_txt     = accept && (req_type_i == REQ_TEXT);
  assign acc_restart = accept && (req_type_i == REQ_RESTART);

  assign txt_active = acc_txt && (pat_len_q != '0);
  assign pat_room   = pat_len_q < CntW'(MAX_PATTERN);
  assign win_clear  = acc_clear | acc_restart | (acc_pat & pat_room);

  assign ptr_last = CntW'(ring_ptr_q) == (pat_len_q - 1'b1);
  assign oldest   = ptr_last ? '0 : RingAw'(ring_ptr_q + 1'b1);
  assign fill_inc = fill_q + 1'b1;

  assign ring_byte = b_ring_fwd_q ? b_byte_q : ring_rd;

  always_comb begin
    need_rd.en   = acc_pat | txt_active | (b_vld_q & b_retire_q);
    need_rd.addr = b_vld_q ? ring_byte : data_byte_i;
    win_rd.en    = txt_active | (b_vld_q & b_retire_q);
    win_rd.addr  = need_rd.addr;
    need_wr.en   = p_vld_q;
    need_wr.addr = b_byte_q;
    need_wdata   = need_rdata + 1'b1;
  end

  always_comb begin
    inc_b     = 1'b0;
    win_b_new = win_rdata;
    if (need_rdata != '0) begin
      win_b_new = win_rdata + 1'b1;
      inc_b     = (win_b_new == need_rdata);
    end
    matched_b = matched_q + CntW'(inc_b);
    match_hit = b_retire_q && (matched_b == distinct_q);

    dec_d     = 1'b0;
    win_d_new = win_rdata;
    if (need_rdata != '0) begin
      dec_d = (win_rdata == need_rdata);
      if (win_rdata != '0) begin
        win_d_new = win_rdata - 1'b1;
      end
    end

    win_wr.en   = b_vld_q | d_vld_q;
    win_wr.addr = b_vld_q ? b_byte_q : d_byte_q;
    win_wdata   = b_vld_q ? win_b_new : win_d_new;
  end

  always_comb begin
    pat_len_d    = pat_len_q;
    distinct_d   = distinct_q;
    matched_d    = matched_q;
    fill_d       = fill_q;
    ring_ptr_d   = ring_ptr_q;
    text_pos_d   = text_pos_q;
    b_vld_d      = txt_active;
    p_vld_d      = acc_pat & pat_room;
    b_byte_d     = data_byte_i;
    b_start_d    = text_pos_q - (PosW'(pat_len_q) - 1'b1);
    b_retire_d   = fill_inc >= pat_len_q;
    b_ring_fwd_d = oldest == ring_ptr_q;
    d_vld_d      = b_vld_q & b_retire_q;
    d_byte_d     = ring_byte;

    if (b_vld_q) begin
      matched_d = matched_b;
    end
    if (d_vld_q) begin
      matched_d = matched_q - CntW'(dec_d);
    end
    if (p_vld_q && (need_rdata == '0)) begin
      distinct_d = distinct_q + 1'b1;
    end

    if (acc_txt) begin
      text_pos_d = text_pos_q + 1'b1;
      if (txt_active) begin
        ring_ptr_d = oldest;
        fill_d     = b_retire_d ? (pat_len_q - 1'b1) : fill_inc;
      end
    end
    if (acc_pat && pat_room) begin
      pat_len_d = pat_len_q + 1'b1;
    end
    if (win_clear) begin
      matched_d  = '0;
      fill_d     = '0;
      ring_ptr_d = '0;
      text_pos_d = '0;
    end
    if (acc_clear) begin
      pat_len_d  = '0;
      distinct_d = '0;
    end
  end

  assign q_push   = b_vld_q & match_hit;
  assign q_pop    = out_valid_o & !out_stall_i;
  assign q_wr_idx = q_cnt_q - 2'(q_pop);

  always_comb begin
    q_data_d = q_data_q;
    if (q_pop) begin
      q_data_d[0] = q_data_q[1];
    end
    if (q_push) begin
      q_data_d[q_wr_idx[0]] = b_start_q;
    end
    q_cnt_d = q_cnt_q + 2'(q_push) - 2'(q_pop);
  end

  assign out_valid_o   = q_cnt_q != '0;
  assign start_index_o = q_data_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= '0;
      distinct_q <= '0;
      matched_q  <= '0;
      fill_q     <= '0;
      ring_ptr_q <= '0;
      text_pos_q <= '0;
      b_vld_q    <= 1'b0;
      p_vld_q    <= 1'b0;
      d_vld_q    <= 1'b0;
      q_cnt_q    <= '0;
    end else begin
      pat_len_q  <= pat_len_d;
      distinct_q <= distinct_d;
      matched_q  <= matched_d;
      fill_q     <= fill_d;
      ring_ptr_q <= ring_ptr_d;
      text_pos_q <= text_pos_d;
      b_vld_q    <= b_vld_d;
      p_vld_q    <= p_vld_d;
      d_vld_q    <= d_vld_d;
      q_cnt_q    <= q_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_byte_q     <= b_byte_d;
    b_start_q    <= b_start_d;
    b_retire_q   <= b_retire_d;
    b_ring_fwd_q <= b_ring_fwd_d;
    d_byte_q     <= d_byte_d;
    q_data_q     <= q_data_d;
  end

  awm_cnt_tbl #(
    .CntW(CntW)
  ) u_need_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(acc_clear),
    .rd_i   (need_rd),
    .wr_i   (need_wr),
    .wdata_i(need_wdata),
    .rdata_o(need_rdata)
  );

  awm_cnt_tbl #(
    .CntW(CntW)
  ) u_win_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clear_i(win_clear),
    .rd_i   (win_rd),
    .wr_i   (win_wr),
    .wdata_i(win_wdata),
    .rdata_o(win_rdata)
  );

  awm_ring_buf #(
    .Depth(MAX_PATTERN),
    .AddrW(RingAw)
  ) u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (txt_active),
    .wr_addr_i(ring_ptr_q),
    .wr_data_i(data_byte_i),
    .rd_en_i  (txt_active),
    .rd_addr_i(oldest),
    .rd_data_o(ring_rd)
  );

  a_stage_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(b_vld_q && (d_vld_q || p_vld_q)))
    else $error("Count-table stages overlap.");

  a_retire_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> $past(b_vld_q))
    else $error("Retire stage without a preceding text stage.");

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q != 2'd3)
    else $error("Result queue overflow.");

  a_matched_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    matched_q <= distinct_q)
    else $error("Matched count exceeds distinct pattern bytes.");

endmodule

FILE: tb/awm_result_checker.sv
// Checker for the sliding-window anagram matcher: watches both channels, predicts
// start indexes from the accepted beats and compares them with the output beats.
// Depends on awm_pkg.
module awm_result_checker #(
  parameter int unsigned MAX_PATTERN = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  logic [1:0]                req_type_i,
  input  logic [awm_pkg::ByteW-1:0] data_byte_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  logic [awm_pkg::PosW-1:0]  start_index_i,
  output int unsigned               fail_count_o,
  output int unsigned               outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import awm_pkg::*;

  logic [8:0]       need_cnt [NumBytes];
  logic [8:0]       win_cnt [NumBytes];
  logic [ByteW-1:0] win_ring [MAX_PATTERN];
  logic [8:0]       pat_len;
  logic [8:0]       distinct_cnt;
  logic [8:0]       matched_cnt;
  logic [8:0]       fill_cnt;
  int unsigned      ring_ptr;
  logic [PosW-1:0]  text_pos;
  logic [PosW-1:0]  expected_starts [$];
  logic [PosW-1:0]  want;
  int unsigned      mismatches;

  function automatic void restart_window();
    for (int i = 0; i < NumBytes; i++) begin
      win_cnt[i] = '0;
    end
    matched_cnt = '0;
    fill_cnt    = '0;
    ring_ptr    = 0;
    text_pos    = '0;
  endfunction

  function automatic void clear_all();
    for (int i = 0; i < NumBytes; i++) begin
      need_cnt[i] = '0;
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_ring[i] = '0;
    end
    pat_len      = '0;
    distinct_cnt = '0;
    restart_window();
  endfunction

  function automatic void predict_window_match(input req_e req, input logic [ByteW-1:0] b);
    logic [PosW-1:0]  pos;
    int unsigned      slot;
    int unsigned      oldest;
    logic [ByteW-1:0] d;
    case (req)
      REQ_CLEAR: begin
        clear_all();
      end
      REQ_RESTART: begin
        restart_window();
      end
      REQ_PATTERN: begin
        if (pat_len < MAX_PATTERN) begin
          need_cnt[b] = need_cnt[b] + 1'b1;
          if (need_cnt[b] == 9'd1) distinct_cnt = distinct_cnt + 1'b1;
          pat_len = pat_len + 1'b1;
          restart_window();
        end
      end
      REQ_TEXT: begin
        pos      = text_pos;
        text_pos = pos + 1'b1;
        if (pat_len != 0) begin
          slot           = ring_ptr % pat_len;
          win_ring[slot] = b;
          if (need_cnt[b] != 0) begin
            win_cnt[b] = win_cnt[b] + 1'b1;
            if (win_cnt[b] == need_cnt[b]) matched_cnt = matched_cnt + 1'b1;
          end
          if (fill_cnt < pat_len) fill_cnt = fill_cnt + 1'b1;
          oldest   = (slot + 1) % pat_len;
          ring_ptr = oldest;
          if (fill_cnt >= pat_len) begin
            if (matched_cnt == distinct_cnt) begin
              expected_starts.push_back(pos - PosW'(pat_len) + 1'b1);
            end
            d = win_ring[oldest];
            if (need_cnt[d] != 0) begin
              if (win_cnt[d] == need_cnt[d]) matched_cnt = matched_cnt - 1'b1;
              if (win_cnt[d] != 0) win_cnt[d] = win_cnt[d] - 1'b1;
            end
            fill_cnt = pat_len - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      expected_starts.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_starts.size() == 0) begin
          $error("start_index: expected none, actual %0d", start_index_i);
          mismatches++;
        end else begin
          want = expected_starts.pop_front();
          if (want !== start_index_i) begin
            $error("start_index: expected %0d, actual %0d", want, start_index_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_window_match(req_e'(req_type_i), data_byte_i);
      end
    end
    outstanding_o <= expected_starts.size();
    fail_count_o  <= mismatches;
  end

endmodule

FILE: tb/tb_anagram_window_matcher_unit.sv
// Top of the anagram matcher testbench: clock, reset, beat stimulus and back-pressure.
// Instantiates anagram_window_matcher_unit and awm_result_checker; depends on awm_pkg.
module tb_anagram_window_matcher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import awm_pkg::*;

  localparam int unsigned MaxPattern  = 256;
  localparam int unsigned BeatTarget  = 1750;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned CycleLimit  = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic [1:0]       req_type_i = REQ_CLEAR;
  logic [ByteW-1:0] data_byte_i = '0;
  logic             out_stall_i = 1'b0;
  logic             in_stall_o;
  logic             out_valid_o;
  logic [PosW-1:0]  start_index_o;
  int unsigned      fail_count;
  int unsigned      outstanding;

  bit               idle_en = 1'b1;
  bit               hold_off_req = 1'b0;
  int unsigned      beats_offered = 0;
  int unsigned      cycles = 0;

  anagram_window_matcher_unit #(
    .MAX_PATTERN(MaxPattern)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .start_index_o(start_index_o)
  );

  awm_result_checker #(
    .MAX_PATTERN(MaxPattern)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .start_index_i(start_index_o),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_anagram_window_matcher_unit: done, errors");
    $finish;
  end

  // The receiver counts its long hold-off itself, then clears the request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= idle_en && ($urandom_range(99) < 27);
      end
    end
  end

  task automatic offer_beat(input req_e req, input logic [ByteW-1:0] b);
    while (idle_en && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_offered++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // A fresh pattern, then text that repeats a shuffled copy of it so that most
  // windows are anagrams, with some corrupted bytes, restarts and late pattern beats.
  task automatic run_session(input int unsigned plen, input int unsigned tlen);
    logic [ByteW-1:0] alphabet [8];
    logic [ByteW-1:0] pat [$];
    logic [ByteW-1:0] tmp;
    int unsigned      asize;
    int unsigned      r;
    int               j;
    asize = $urandom_range(1, 8);
    for (int k = 0; k < 8; k++) begin
      alphabet[k] = ByteW'($urandom_range(255));
    end
    offer_beat(REQ_CLEAR, ByteW'($urandom));
    for (int k = 0; k < plen; k++) begin
      tmp = alphabet[$urandom_range(asize - 1)];
      offer_beat(REQ_PATTERN, tmp);
      if (pat.size() < MaxPattern) pat.push_back(tmp);
    end
    for (int k = pat.size() - 1; k > 0; k--) begin
      j      = $urandom_range(k);
      tmp    = pat[k];
      pat[k] = pat[j];
      pat[j] = tmp;
    end
    for (int k = 0; k < tlen; k++) begin
      r = $urandom_range(99);
      if (r < 2) begin
        offer_beat(REQ_RESTART, ByteW'($urandom));
      end else if (r < 3 && pat.size() < MaxPattern) begin
        tmp = alphabet[$urandom_range(asize - 1)];
        offer_beat(REQ_PATTERN, tmp);
        pat.push_back(tmp);
      end else if (r < 6 || pat.size() == 0) begin
        offer_beat(REQ_TEXT, alphabet[$urandom_range(asize - 1)]);
      end else if (r < 9) begin
        offer_beat(REQ_TEXT, ByteW'($urandom));
      end else begin
        offer_beat(REQ_TEXT, pat[k % pat.size()]);
      end
    end
  endtask

  initial begin
    int unsigned sess;
    int unsigned plen;
    int unsigned r;
    sess = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_beat(REQ_CLEAR, 8'hA5);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'hFF);
    offer_beat(REQ_PATTERN, 8'h00);
    offer_beat(REQ_PATTERN, 8'hFF);
    offer_beat(REQ_PATTERN, 8'h00);
    offer_beat(REQ_TEXT, 8'hFF);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'h55);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'hFF);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_PATTERN, 8'h55);
    offer_beat(REQ_TEXT, 8'h55);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'hFF);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_RESTART, 8'h3C);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'h00);
    offer_beat(REQ_TEXT, 8'hFF);
    offer_beat(REQ_TEXT, 8'h55);
    offer_beat(REQ_CLEAR, 8'hC3);
    offer_beat(REQ_TEXT, 8'hAA);
    drain_results();

    while (beats_offered < BeatTarget) begin
      idle_en = !(sess >= 12 && sess < 24);
      r = $urandom_range(99);
      if (sess == 3) begin
        run_session(MaxPattern + 4, 270);
      end else if (sess == 6) begin
        hold_off_req = 1'b1;
        run_session(1, 60);
        drain_results();
      end else if (r < 10) begin
        repeat ($urandom_range(4, 16)) begin
          offer_beat(req_e'($urandom_range(3)), ByteW'($urandom));
        end
      end else begin
        r = $urandom_range(99);
        if (r < 3) plen = 0;
        else if (r < 60) plen = $urandom_range(1, 4);
        else if (r < 90) plen = $urandom_range(5, 12);
        else plen = $urandom_range(13, 32);
        run_session(plen, (plen + 1) * $urandom_range(2, 5) + $urandom_range(8));
      end
      if ($urandom_range(9) == 0) drain_results();
      sess++;
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_anagram_window_matcher_unit: done, clean");
    end else begin
      $display("tb_anagram_window_matcher_unit: done, errors");
    end
    $finish;
  end

endmodule

FILE: anagram_window_matcher_unit.f
rtl/awm_pkg.sv
rtl/awm_cnt_tbl.sv
rtl/awm_ring_buf.sv
rtl/anagram_window_matcher_unit.sv
tb/awm_result_checker.sv
tb/tb_anagram_window_matcher_unit.sv
